>>> design/kscl_pkg.sv
// Shared types and constants for the keypad scan code lock.
`default_nettype none

package kscl_pkg;

  localparam int unsigned KEY_W      = 4;
  localparam int unsigned KEYS_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEB_W      = 16;
  localparam int unsigned SECRET_W   = 20;
  localparam int unsigned SLEN_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned VERDICT_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_KEY = 2'd3;

  // Configuration reset values
  localparam logic [DEB_W-1:0]    DEBOUNCE_RST  = 16'd300;
  localparam logic [SECRET_W-1:0] SECRET_RST    = 20'd0;
  localparam logic [SLEN_W-1:0]   SECRET_LEN_RST = 3'd0;
  localparam logic [KEY_W-1:0]    ENTER_KEY_RST = 4'd14;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OK   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } kscl_state_e;

  typedef struct packed {
    logic             append;
    logic             clear;
    logic [KEY_W-1:0] key;
  } code_ctrl_t;

  typedef struct packed {
    logic match;
    logic full;
  } code_stat_t;

endpackage

`default_nettype wire

>>> design/kscl_if.sv
// Handshake channel interfaces: snapshot input, key result output, configuration write.
`default_nettype none

interface kscl_in_if;
  logic                         valid;
  logic                         ready;
  logic [kscl_pkg::KEYS_W-1:0]  pressed_keys;
  logic [kscl_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, pressed_keys, now_ms, input ready);
  modport sink   (input valid, pressed_keys, now_ms, output ready);
endinterface

interface kscl_out_if;
  logic                           valid;
  logic                           ready;
  logic [kscl_pkg::KEY_W-1:0]     key_index;
  logic                           is_enter;
  logic [kscl_pkg::VERDICT_W-1:0] verdict;
  logic                           overflow_cleared;
  logic                           unlocked;
  logic                           last;

  modport source (output valid, key_index, is_enter, verdict, overflow_cleared, unlocked,
                  last, input ready);
  modport sink   (input valid, key_index, is_enter, verdict, overflow_cleared, unlocked,
                  last, output ready);
endinterface

interface kscl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kscl_pkg::CFG_IDX_W-1:0]  index;
  logic [kscl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/kscl_code.sv
// Entered code store with length and content match against the secret code.
`default_nettype none

module kscl_code #(
  parameter int unsigned MAX_CODE = 5
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire kscl_pkg::code_ctrl_t             ctrl_i,
  input  wire logic [kscl_pkg::SECRET_W-1:0]    secret_code_i,
  input  wire logic [kscl_pkg::SLEN_W-1:0]      secret_length_i,
  output kscl_pkg::code_stat_t                  stat_o
);
  import kscl_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CODE + 1);
  localparam int unsigned IDX_W = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1;

  logic [KEY_W-1:0] entries_q [MAX_CODE];
  logic [CNT_W-1:0] count_q, count_d;
  logic             content_ok;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.append) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Entries carry no reset; only those below the count are ever compared.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_CODE; i++) begin
      if (ctrl_i.append && count_q == CNT_W'(i)) begin
        entries_q[IDX_W'(i)] <= ctrl_i.key;
      end
    end
  end

  always_comb begin
    content_ok = 1'b1;
    for (int i = 0; i < MAX_CODE; i++) begin
      if (CNT_W'(i) < count_q &&
          entries_q[IDX_W'(i)] != secret_code_i[KEY_W*i +: KEY_W]) begin
        content_ok = 1'b0;
      end
    end
  end

  assign stat_o.match = content_ok && (SLEN_W'(count_q) == secret_length_i);
  assign stat_o.full  = (count_q == CNT_W'(MAX_CODE));

endmodule

`default_nettype wire

>>> design/keypad_scan_code_lock.sv
// Keypad matrix scanner with debounce and code lock, top level.
//
//   channel | dir | handshake            | payload
//   in_i    | in  | valid / ready        | pressed_keys, now_ms
//   out_o   | out | valid / ready        | key_index, is_enter, verdict, overflow_cleared,
//           |     |                      | unlocked, last
//   cfg_i   | in  | valid / ready (=1)   | index, data
//
// A snapshot is captured first, then scanned one column at a time.
// Every column step shares one 32-bit elapsed-time subtract and debounce compare.
// A column that finds a key waits while the output register holds an untaken result.
// A new snapshot is taken only when the scan is done; results may still be pending.
// Reset restores the configuration defaults and clears the lock state.
`default_nettype none

module keypad_scan_code_lock #(
  parameter int unsigned ROWS     = 4,
  parameter int unsigned COLS     = 4,
  parameter int unsigned MAX_CODE = 5
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kscl_in_if.sink     in_i,
  kscl_out_if.source  out_o,
  kscl_cfg_if.sink    cfg_i
);
  import kscl_pkg::*;

  localparam int unsigned COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  // Configuration
  logic [DEB_W-1:0]    deb_q;
  logic [SECRET_W-1:0] secret_q;
  logic [SLEN_W-1:0]   slen_q;
  logic [KEY_W-1:0]    enter_q;

  // Scan control and snapshot
  kscl_state_e       state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [KEYS_W-1:0] keys_q;
  logic [TIME_W-1:0] now_q;
  logic              in_ready;
  logic              scan_en;

  // Lock state
  logic [KEY_W-1:0]  last_key_q;
  logic              last_key_vld_q;
  logic [TIME_W-1:0] last_ms_q;
  logic              complete_q;

  // Output register
  logic                 out_vld_q, out_vld_d;
  logic [KEY_W-1:0]     out_key_q;
  logic                 out_enter_q;
  logic [VERDICT_W-1:0] out_verdict_q;
  logic                 out_ovf_q;
  logic                 out_unlocked_q;
  logic                 out_last_q;

  // Column datapath
  logic [TIME_W-1:0]    elapsed;
  logic                 blocked;
  logic                 hit;
  logic [KEY_W-1:0]     pick;
  logic                 later;
  logic                 out_free;
  logic                 step;
  logic                 take;
  logic                 is_enter;
  logic                 ovf;
  logic [VERDICT_W-1:0] verdict;
  logic                 complete_d;
  logic                 last_col;

  code_ctrl_t code_ctrl;
  code_stat_t code_stat;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= DEBOUNCE_RST;
      secret_q <= SECRET_RST;
      slen_q   <= SECRET_LEN_RST;
      enter_q  <= ENTER_KEY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DEBOUNCE:   deb_q    <= cfg_i.data[DEB_W-1:0];
        CFG_SECRET:     secret_q <= cfg_i.data[SECRET_W-1:0];
        CFG_SECRET_LEN: slen_q   <= cfg_i.data[SLEN_W-1:0];
        CFG_ENTER_KEY:  enter_q  <= cfg_i.data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- column unit
  assign elapsed = now_q - last_ms_q;
  assign blocked = last_key_vld_q && (elapsed <= TIME_W'(deb_q));

  // Lowest pressed row wins; drop the last key while it is still in debounce.
  always_comb begin
    logic [KEY_W-1:0] idx;
    hit  = 1'b0;
    pick = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      idx = KEY_W'(r * COLS) + KEY_W'(col_q);
      if (keys_q[idx] && !(blocked && last_key_q == idx)) begin
        hit  = 1'b1;
        pick = idx;
      end
    end
  end

  // Once a key in this column is taken, no later key can be in debounce,
  // so any pressed key in a later column yields another result.
  always_comb begin
    later = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (COL_W'(c) > col_q && keys_q[KEY_W'(r * COLS + c)]) begin
          later = 1'b1;
        end
      end
    end
  end

  assign out_free = !out_vld_q || out_o.ready;
  assign step     = scan_en && (!hit || out_free);
  assign take     = step && hit;
  assign last_col = (col_q == COL_W'(COLS - 1));

  assign is_enter = (pick == enter_q);
  assign ovf      = !is_enter && code_stat.full;

  always_comb begin
    verdict    = VERDICT_NONE;
    complete_d = complete_q;
    if (is_enter) begin
      verdict    = code_stat.match ? VERDICT_OK : VERDICT_BAD;
      complete_d = code_stat.match;
    end
  end

  assign code_ctrl.append = take && !is_enter && !code_stat.full;
  assign code_ctrl.clear  = take && (is_enter || code_stat.full);
  assign code_ctrl.key    = pick;

  kscl_code #(
    .MAX_CODE (MAX_CODE)
  ) u_code (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (code_ctrl),
    .secret_code_i   (secret_q),
    .secret_length_i (slen_q),
    .stat_o          (code_stat)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    case (state_q)
      ST_IDLE: begin
        col_d = '0;
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (last_col) begin
            state_d = ST_IDLE;
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        col_d   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scan_en  = 1'b1;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      keys_q <= in_i.pressed_keys;
      now_q  <= in_i.now_ms;
    end
  end

  // ---------------------------------------------------------------- lock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q     <= '0;
      last_key_vld_q <= 1'b0;
      last_ms_q      <= '0;
      complete_q     <= 1'b0;
    end else if (take) begin
      last_key_q     <= pick;
      last_key_vld_q <= 1'b1;
      last_ms_q      <= now_q;
      complete_q     <= complete_d;
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (take) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_key_q      <= pick;
      out_enter_q    <= is_enter;
      out_verdict_q  <= verdict;
      out_ovf_q      <= ovf;
      out_unlocked_q <= complete_d;
      out_last_q     <= !later;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.key_index        = out_key_q;
  assign out_o.is_enter         = out_enter_q;
  assign out_o.verdict          = out_verdict_q;
  assign out_o.overflow_cleared = out_ovf_q;
  assign out_o.unlocked         = out_unlocked_q;
  assign out_o.last             = out_last_q;

  // ---------------------------------------------------------------- assertions
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !in_i.ready)
    else $error("snapshot channel ready during scan");

  a_enter_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_enter |->
      !out_o.overflow_cleared && (out_o.unlocked == (out_o.verdict == VERDICT_OK)))
    else $error("enter result inconsistent");

  a_key_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_enter |-> out_o.verdict == VERDICT_NONE)
    else $error("verdict on non-enter key");

  a_take_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_vld_q && out_key_q == $past(pick) && last_key_q == out_key_q)
    else $error("accepted key not registered");

endmodule

`default_nettype wire
